// ----- rtl/mcpr_pkg.sv -----
// Shared types, constants and register codes for the motor command packet receiver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mcpr_pkg;

   localparam int NUM_CHANNELS_DEF = 8;

   localparam int BYTE_W      = 8;
   localparam int CMD_RAW_W   = 16;
   localparam int CMD_W       = 11;
   localparam int PULSE_W     = 12;
   localparam int TICK_W      = 24;
   localparam int CH_OUT_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Scaling: cmd * span / 2000, divide done as reciprocal multiply plus one correction.
   localparam int PROD_W       = CMD_W + PULSE_W;
   localparam int RECIP_W      = 22;
   localparam int RECIP_PROD_W = PROD_W + RECIP_W;
   localparam int RECIP_SHIFT  = 32;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd2000);
   localparam logic [CMD_W-1:0]   CMD_FULL = 11'd2000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_BYTE    = 3'd0,
      CSR_TIMEOUT_TICKS = 3'd1,
      CSR_PULSE_MIN     = 3'd2,
      CSR_PULSE_MAX     = 3'd3,
      CSR_PULSE_NEUTRAL = 3'd4
   } csr_index_type;

   typedef enum logic {
      ITEM_BYTE = 1'b0,
      ITEM_TICK = 1'b1
   } item_type;

   typedef enum logic {
      CAUSE_FRAME   = 1'b0,
      CAUSE_TIMEOUT = 1'b1
   } cause_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SPAN,
      BK_RECIP,
      BK_CORR,
      BK_SEND
   } back_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  start_byte;
      logic [TICK_W-1:0]  timeout_ticks;
      logic [PULSE_W-1:0] pulse_min;
      logic [PULSE_W-1:0] pulse_max;
      logic [PULSE_W-1:0] pulse_neutral;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_byte:    8'h5A,
      timeout_ticks: 24'd200000,
      pulse_min:     12'd1000,
      pulse_max:     12'd2000,
      pulse_neutral: 12'd1500
   };

   typedef struct packed {
      logic      push;
      cause_type cause;
   } job_ctl_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      cause_type cause;
   } queue_status_type;

endpackage

// ----- rtl/mcpr_if.sv -----
// Handshake interfaces for the request (byte/tick) and response (channel update) channels.
// Depends on mcpr_pkg for field widths.
`timescale 1ns / 1ps

interface mcpr_req_if;
   import mcpr_pkg::*;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BYTE_W-1:0] byte_value;

   modport source (output valid, req_type, byte_value, input ready);
   modport sink   (input valid, req_type, byte_value, output ready);
endinterface

interface mcpr_rsp_if;
   import mcpr_pkg::*;
   logic                valid;
   logic                ready;
   logic [CH_OUT_W-1:0] channel;
   logic [PULSE_W-1:0]  pulse_us;
   logic                cause;
   logic                last;

   modport source (output valid, channel, pulse_us, cause, last, input ready);
   modport sink   (input valid, channel, pulse_us, cause, last, output ready);
endinterface

// ----- rtl/mcpr_front.sv -----
// Front end: frame parser, checksum, command store and tick/timeout tracking.
// Depends on mcpr_pkg and mcpr_req_if; pushes jobs toward mcpr_queue.
`timescale 1ns / 1ps

module mcpr_front #(
   parameter int NUM_CHANNELS = mcpr_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   mcpr_req_if.sink                                  req_bus,
   input  mcpr_pkg::cfg_type                         cfg,
   input  logic                                      queue_full,
   output mcpr_pkg::job_ctl_type                     job_ctl,
   output logic [NUM_CHANNELS-1:0][mcpr_pkg::CMD_W-1:0] job_cmds
);
   import mcpr_pkg::*;

   localparam int FRAME_LAST = 2 * NUM_CHANNELS + 1;
   localparam int BC_W       = $clog2(FRAME_LAST + 1);
   localparam int SLOT_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [BC_W-1:0]   BC_LAST  = BC_W'(FRAME_LAST);
   localparam logic [BC_W-1:0]   BC_ONE   = BC_W'(1);
   localparam logic [BC_W-1:0]   BC_TWO   = BC_W'(2);
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   logic [BC_W-1:0]      byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]    xor_ff, xor_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic                 failsafe_ff, failsafe_in;
   logic [BYTE_W-1:0]    low_half_ff;
   logic [CMD_RAW_W-1:0] cmd_store_ff [NUM_CHANNELS];

   logic                 accept;
   logic                 low_we;
   logic                 cmd_we;
   logic [TICK_W-1:0]    tick_next;
   logic [BC_W-1:0]      bc_minus_two;
   logic [SLOT_W-1:0]    slot;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign tick_next     = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign bc_minus_two  = byte_count_ff - BC_TWO;
   assign slot          = bc_minus_two[SLOT_W:1];

   always_comb begin
      byte_count_in = byte_count_ff;
      xor_in        = xor_ff;
      tick_in       = tick_ff;
      failsafe_in   = failsafe_ff;
      low_we        = 1'b0;
      cmd_we        = 1'b0;
      job_ctl.push  = 1'b0;
      job_ctl.cause = CAUSE_FRAME;

      if (accept) begin
         if (item_type'(req_bus.req_type) == ITEM_TICK) begin
            tick_in = tick_next;
            if (tick_next > cfg.timeout_ticks && !failsafe_ff) begin
               failsafe_in   = 1'b1;
               byte_count_in = '0;
               xor_in        = '0;
               job_ctl.push  = 1'b1;
               job_ctl.cause = CAUSE_TIMEOUT;
            end
         end else if (byte_count_ff == '0) begin
            // hunting for the start byte
            if (req_bus.byte_value == cfg.start_byte) begin
               xor_in        = req_bus.byte_value;
               byte_count_in = BC_ONE;
            end
         end else if (byte_count_ff < BC_LAST) begin
            if (byte_count_ff[0]) begin
               low_we = 1'b1;
            end else begin
               cmd_we = 1'b1;
            end
            xor_in        = xor_ff ^ req_bus.byte_value;
            byte_count_in = byte_count_ff + 1'b1;
         end else begin
            // checksum byte
            byte_count_in = '0;
            xor_in        = '0;
            if (req_bus.byte_value == xor_ff) begin
               tick_in      = '0;
               failsafe_in  = 1'b0;
               job_ctl.push = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         xor_ff        <= '0;
         tick_ff       <= '0;
         failsafe_ff   <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         xor_ff        <= xor_in;
         tick_ff       <= tick_in;
         failsafe_ff   <= failsafe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (low_we) begin
         low_half_ff <= req_bus.byte_value;
      end
      if (cmd_we) begin
         cmd_store_ff[slot] <= {req_bus.byte_value, low_half_ff};
      end
   end

   // clamp to full scale as the job is handed over
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         job_cmds[i] = (cmd_store_ff[i] > CMD_RAW_W'(CMD_FULL)) ? CMD_FULL
                                                                : cmd_store_ff[i][CMD_W-1:0];
      end
   end

endmodule

// ----- rtl/mcpr_queue.sv -----
// Two-entry job queue between the frame parser and the update sequencer.
// Depends on mcpr_pkg.
`timescale 1ns / 1ps

module mcpr_queue #(
   parameter int NUM_CHANNELS = mcpr_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mcpr_pkg::job_ctl_type                     push_ctl,
   input  logic [NUM_CHANNELS-1:0][mcpr_pkg::CMD_W-1:0] push_cmds,
   input  logic                                      pop,
   output mcpr_pkg::queue_status_type                status,
   output logic [NUM_CHANNELS-1:0][mcpr_pkg::CMD_W-1:0] head_cmds
);
   import mcpr_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;
   localparam int CNT_W = 2;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cause_type                          cause_mem_ff [DEPTH];
   logic [NUM_CHANNELS-1:0][CMD_W-1:0] cmds_mem_ff  [DEPTH];
   logic [PTR_W-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ctl.push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push_ctl.push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ctl.push) begin
         cause_mem_ff[wr_ptr_ff] <= push_ctl.cause;
         cmds_mem_ff[wr_ptr_ff]  <= push_cmds;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_FULL);
   assign status.cause = cause_mem_ff[rd_ptr_ff];
   assign head_cmds    = cmds_mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/mcpr_back.sv -----
// Back end: walks the channels of one job, scales each command and drives the response channel.
// Depends on mcpr_pkg and mcpr_rsp_if; pops jobs from mcpr_queue.
`timescale 1ns / 1ps

module mcpr_back #(
   parameter int NUM_CHANNELS = mcpr_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mcpr_pkg::cfg_type                         cfg,
   input  mcpr_pkg::queue_status_type                status,
   input  logic [NUM_CHANNELS-1:0][mcpr_pkg::CMD_W-1:0] head_cmds,
   output logic                                      pop,
   mcpr_rsp_if.source                                rsp_bus
);
   import mcpr_pkg::*;

   localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [SLOT_W-1:0] LAST_CH = SLOT_W'(NUM_CHANNELS - 1);

   back_state_type                     state_ff, state_in;
   logic [SLOT_W-1:0]                  ch_ff, ch_in;
   cause_type                          cause_ff, cause_in;
   logic [NUM_CHANNELS-1:0][CMD_W-1:0] cmds_ff;
   logic [PROD_W-1:0]                  prod_ff;
   logic [PULSE_W-1:0]                 qest_ff;
   logic [PULSE_W-1:0]                 pulse_ff;

   logic [CMD_W-1:0]        cmd_sel;
   logic [PULSE_W-1:0]      span;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [PROD_W-1:0]       back_prod;
   logic [PROD_W-1:0]       remainder;
   logic [PULSE_W-1:0]      quotient;

   assign cmd_sel    = cmds_ff[ch_ff];
   assign span       = (cfg.pulse_max > cfg.pulse_min) ? cfg.pulse_max - cfg.pulse_min : '0;
   assign recip_prod = RECIP_PROD_W'(prod_ff) * RECIP_PROD_W'(RECIP);
   assign back_prod  = PROD_W'(qest_ff) * PROD_W'(CMD_FULL);
   assign remainder  = prod_ff - back_prod;
   // reciprocal estimate is at most one low
   assign quotient   = (remainder >= PROD_W'(CMD_FULL)) ? qest_ff + 1'b1 : qest_ff;

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      cause_in      = cause_ff;
      pop           = 1'b0;
      rsp_bus.valid = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!status.empty) begin
               pop      = 1'b1;
               cause_in = status.cause;
               ch_in    = '0;
               state_in = (status.cause == CAUSE_TIMEOUT) ? BK_SEND : BK_SPAN;
            end
         end
         BK_SPAN:  state_in = BK_RECIP;
         BK_RECIP: state_in = BK_CORR;
         BK_CORR:  state_in = BK_SEND;
         BK_SEND: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               if (ch_ff == LAST_CH) begin
                  state_in = BK_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = (cause_ff == CAUSE_TIMEOUT) ? BK_SEND : BK_SPAN;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         ch_ff    <= '0;
         cause_ff <= CAUSE_FRAME;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         cause_ff <= cause_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmds_ff <= head_cmds;
      end
      if (state_ff == BK_SPAN) begin
         prod_ff <= PROD_W'(cmd_sel) * PROD_W'(span);
      end
      if (state_ff == BK_RECIP) begin
         qest_ff <= recip_prod[RECIP_SHIFT +: PULSE_W];
      end
      if (state_ff == BK_CORR) begin
         pulse_ff <= cfg.pulse_min + quotient;
      end
   end

   assign rsp_bus.channel  = CH_OUT_W'(ch_ff);
   assign rsp_bus.pulse_us = (cause_ff == CAUSE_TIMEOUT) ? cfg.pulse_neutral : pulse_ff;
   assign rsp_bus.cause    = cause_ff;
   assign rsp_bus.last     = (ch_ff == LAST_CH);

endmodule

// ----- rtl/motor_command_packet_receiver_unit.sv -----
// Top level of the motor command packet receiver: register file plus front, queue and back.
// Depends on mcpr_pkg, mcpr_if, mcpr_front, mcpr_queue and mcpr_back.
`timescale 1ns / 1ps

// Usage
//   req_bus: one transfer per link byte (req_type 0) or per time tick (req_type 1).
//     Every item is taken by the frame parser as it is transferred; no item produces a response
//     except the checksum byte of a good frame and the tick that trips the timeout.
//   rsp_bus: a burst of NUM_CHANNELS channel updates, channel 0 first, last set on
//     the final one. cause 0 = frame applied, cause 1 = failsafe neutral.
//   csr_*: write-only registers (start byte, timeout, pulse min/max/neutral),
//     which the user must write only while the block is idle; the block does not enforce this.
// Sequencing
//   A good checksum byte queues a job that the sequencer pops; each update of a frame
//   goes through scale multiply, reciprocal multiply, correction and send, and the next
//   channel starts only after the current update is taken. A timeout burst gives one update
//   per cycle while rsp_bus.ready is high. The scaling datapath in the back end is shared.
//   req_bus.ready drops only while the two-entry job queue is full, i.e. two
//   bursts wait behind the one being sent.
// Reset: synchronous. Parser, tick counter, failsafe flag, queue and sequencer clear;
//   registers return to their defaults (start 0x5A, timeout 200000, 1000/2000/1500).
// Stalls
//   With rsp_bus.ready low the current update holds; the parser keeps accepting
//   bytes until the queue fills.

module motor_command_packet_receiver_unit #(
   parameter int NUM_CHANNELS = mcpr_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mcpr_req_if.sink                            req_bus,
   mcpr_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [mcpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mcpr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcpr_pkg::*;

   cfg_type                            cfg_ff, cfg_in;
   job_ctl_type                        job_ctl;
   queue_status_type                   q_status;
   logic [NUM_CHANNELS-1:0][CMD_W-1:0] job_cmds;
   logic [NUM_CHANNELS-1:0][CMD_W-1:0] head_cmds;
   logic                               pop;

   // register file; writes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_BYTE:    cfg_in.start_byte    = csr_wdata[BYTE_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[TICK_W-1:0];
            CSR_PULSE_MIN:     cfg_in.pulse_min     = csr_wdata[PULSE_W-1:0];
            CSR_PULSE_MAX:     cfg_in.pulse_max     = csr_wdata[PULSE_W-1:0];
            CSR_PULSE_NEUTRAL: cfg_in.pulse_neutral = csr_wdata[PULSE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // parser: accepts every item while the queue has room, hands good frames and timeouts on as jobs
   mcpr_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (q_status.full),
      .job_ctl    (job_ctl),
      .job_cmds   (job_cmds)
   );

   // job queue carries a clamped snapshot of the commands, so the next frame
   // may overwrite the parser's store while a burst is still going out
   mcpr_queue #(.NUM_CHANNELS(NUM_CHANNELS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_ctl  (job_ctl),
      .push_cmds (job_cmds),
      .pop       (pop),
      .status    (q_status),
      .head_cmds (head_cmds)
   );

   // update sequencer and scaling datapath
   mcpr_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .status    (q_status),
      .head_cmds (head_cmds),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- rtl/mcpr_checker.sv -----
// Port-level checks on the response channel of the receiver, bound to the top level.
// Depends on mcpr_pkg for widths.
`timescale 1ns / 1ps

module mcpr_checker #(
   parameter int NUM_CHANNELS = mcpr_pkg::NUM_CHANNELS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mcpr_pkg::CH_OUT_W-1:0]    rsp_channel,
   input logic [mcpr_pkg::PULSE_W-1:0]     rsp_pulse_us,
   input logic                             rsp_cause,
   input logic                             rsp_last
);
   import mcpr_pkg::*;

   localparam logic [CH_OUT_W-1:0] LAST_CH = CH_OUT_W'(NUM_CHANNELS - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_channel) && $stable(rsp_pulse_us)
                                  && $stable(rsp_cause) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_channel == LAST_CH)
      else $error("burst ended on the wrong channel");

endmodule

bind motor_command_packet_receiver_unit mcpr_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_channel  (rsp_bus.channel),
   .rsp_pulse_us (rsp_bus.pulse_us),
   .rsp_cause    (rsp_bus.cause),
   .rsp_last     (rsp_bus.last)
);

// ----- tb/motor_command_packet_receiver_unit_tb.sv -----
// Testbench for motor_command_packet_receiver_unit: link frames, ticks and CSR writes.
// A local predictor checks every channel update; uses mcpr_pkg and mcpr_if from the RTL.
`timescale 1ns / 1ps

module motor_command_packet_receiver_unit_tb;
   import mcpr_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int CHANNELS       = NUM_CHANNELS_DEF;
   localparam int FRAME_LAST     = 2 * CHANNELS + 1;   // position of the checksum byte
   localparam int FULL_SCALE     = 2000;
   localparam int SETTLE_CYCLES  = 16;                  // settle time after the queues drain
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 64;
   localparam int CSR_INDEX_LIMIT = 5;                  // first index past the register list

   typedef struct {
      item_type          kind;
      logic [BYTE_W-1:0] value;
   } link_item_type;

   typedef struct {
      logic [CH_OUT_W-1:0] channel;
      logic [PULSE_W-1:0]  pulse_us;
      cause_type           cause;
      logic                last;
   } channel_update_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mcpr_req_if req_bus ();
   mcpr_rsp_if rsp_bus ();

   motor_command_packet_receiver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Items waiting to be driven and channel updates waiting to be seen.
   link_item_type      link_items[$];
   channel_update_type expected_updates[$];
   int                 items_queued = 0;
   int                 mismatches   = 0;
   bit                 idling_on    = 1'b1;

   // Predictor copy of the registers and the frame parser state.
   cfg_type           rx_cfg      = CFG_RESET;
   logic [4:0]        frame_pos   = '0;
   logic [BYTE_W-1:0] frame_xor   = '0;
   logic [BYTE_W-1:0] low_byte    = '0;
   logic [15:0]       cmd_store [CHANNELS];
   logic [TICK_W-1:0] tick_total  = '0;
   logic              failsafe_on = 1'b0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Command clamped to full scale, then mapped onto [pulse_min, pulse_max];
   // an inverted range has zero span and pins every channel to pulse_min.
   function automatic logic [PULSE_W-1:0] scaled_pulse(input logic [15:0] raw);
      int span;
      int cmd;
      span = (rx_cfg.pulse_max > rx_cfg.pulse_min) ?
             int'(rx_cfg.pulse_max) - int'(rx_cfg.pulse_min) : 0;
      cmd  = (int'(raw) > FULL_SCALE) ? FULL_SCALE : int'(raw);
      return PULSE_W'(int'(rx_cfg.pulse_min) + cmd * span / FULL_SCALE);
   endfunction

   task automatic queue_burst(input cause_type cause);
      channel_update_type u;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         u.channel  = CH_OUT_W'(ch);
         u.pulse_us = (cause == CAUSE_TIMEOUT) ? rx_cfg.pulse_neutral : scaled_pulse(cmd_store[ch]);
         u.cause    = cause;
         u.last     = (ch == CHANNELS - 1);
         expected_updates.push_back(u);
      end
   endtask

   task automatic predict_updates(input item_type kind, input logic [BYTE_W-1:0] value);
      int slot;
      if (kind == ITEM_TICK) begin
         if (tick_total != '1)
            tick_total = tick_total + 1'b1;
         // timeout: drop any open frame, go neutral once
         if (tick_total > rx_cfg.timeout_ticks && !failsafe_on) begin
            failsafe_on = 1'b1;
            frame_pos   = '0;
            frame_xor   = '0;
            queue_burst(CAUSE_TIMEOUT);
         end
      end else if (frame_pos == 0) begin
         // no open frame: only the start byte matters
         if (value == rx_cfg.start_byte) begin
            frame_xor = value;
            frame_pos = 5'd1;
         end
      end else if (frame_pos < FRAME_LAST) begin
         if (frame_pos[0]) begin
            low_byte = value;
         end else begin
            slot = (int'(frame_pos) - 2) / 2;
            cmd_store[slot] = {value, low_byte};
         end
         frame_xor = frame_xor ^ value;
         frame_pos = frame_pos + 1'b1;
      end else begin
         // checksum byte: apply on match, silent drop otherwise
         frame_pos = '0;
         if (value == frame_xor) begin
            tick_total  = '0;
            failsafe_on = 1'b0;
            queue_burst(CAUSE_FRAME);
         end
         frame_xor = '0;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   task automatic queue_byte(input logic [BYTE_W-1:0] value);
      link_item_type it;
      it.kind  = ITEM_BYTE;
      it.value = value;
      link_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_tick();
      link_item_type it;
      it.kind  = ITEM_TICK;
      it.value = BYTE_W'($urandom);   // payload is don't-care on ticks
      link_items.push_back(it);
      items_queued++;
   endtask

   // Full frame; spoil flips one checksum bit, tick_noise sprinkles ticks inside.
   task automatic queue_frame(input logic [15:0] cmds [CHANNELS], input bit spoil,
                              input bit tick_noise);
      logic [BYTE_W-1:0] check;
      check = rx_cfg.start_byte;
      queue_byte(rx_cfg.start_byte);
      foreach (cmds[k]) begin
         queue_byte(cmds[k][7:0]);
         if (tick_noise && $urandom_range(0, 9) == 0)
            queue_tick();
         queue_byte(cmds[k][15:8]);
         check = check ^ cmds[k][7:0] ^ cmds[k][15:8];
      end
      if (spoil)
         check = check ^ BYTE_W'(1 << $urandom_range(0, 7));
      queue_byte(check);
   endtask

   function automatic logic [15:0] random_command();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'(FULL_SCALE);
         2:       return 16'($urandom_range(FULL_SCALE + 1, 16'hFFFF));
         default: return 16'($urandom_range(0, FULL_SCALE));
      endcase
   endfunction

   // Half good frames; the rest bad checksums, cut frames, noise and tick runs.
   task automatic queue_random_traffic(input int count);
      int          stop;
      logic [15:0] cmds [CHANNELS];
      stop = items_queued + count;
      while (items_queued < stop) begin
         foreach (cmds[k])
            cmds[k] = random_command();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: queue_frame(cmds, 1'b0, 1'b1);
            5:             queue_frame(cmds, 1'b1, 1'b1);
            6: begin
               // frame cut short; the parser resyncs on a later checksum miss
               queue_byte(rx_cfg.start_byte);
               repeat ($urandom_range(1, 2 * CHANNELS))
                  queue_byte(BYTE_W'($urandom));
            end
            7:       repeat ($urandom_range(1, 4)) queue_byte(BYTE_W'($urandom));
            default: repeat ($urandom_range(1, 8)) queue_tick();
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Register writes (block idle only)
   // ------------------------------------------------------------------

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_START_BYTE:    rx_cfg.start_byte    = data[BYTE_W-1:0];
         CSR_TIMEOUT_TICKS: rx_cfg.timeout_ticks = data[TICK_W-1:0];
         CSR_PULSE_MIN:     rx_cfg.pulse_min     = data[PULSE_W-1:0];
         CSR_PULSE_MAX:     rx_cfg.pulse_max     = data[PULSE_W-1:0];
         CSR_PULSE_NEUTRAL: rx_cfg.pulse_neutral = data[PULSE_W-1:0];
         default: ;
      endcase
   endtask

   // Upper data bits carry junk to check width masking; one write goes to an
   // unmapped index and must be ignored.
   task automatic load_config(input logic [BYTE_W-1:0] start, input logic [TICK_W-1:0] timeout,
                              input logic [PULSE_W-1:0] floor_us,
                              input logic [PULSE_W-1:0] ceil_us,
                              input logic [PULSE_W-1:0] neutral_us);
      write_reg(CSR_START_BYTE,    {16'($urandom), start});
      write_reg(CSR_TIMEOUT_TICKS, timeout);
      write_reg(CSR_PULSE_MIN,     {12'($urandom), floor_us});
      write_reg(CSR_PULSE_MAX,     {12'($urandom), ceil_us});
      write_reg(CSR_PULSE_NEUTRAL, {12'($urandom), neutral_us});
      write_reg(CSR_INDEX_W'($urandom_range(CSR_INDEX_LIMIT, 7)), CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the sender until every queued item is taken and every update has
   // arrived, then give the parser time to finish silent items.
   task automatic wait_for_quiet();
      do
         @(posedge clock);
      while (link_items.size() != 0 || req_bus.valid || expected_updates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Request driver: one item per transfer, with random idle gaps
   // ------------------------------------------------------------------

   logic req_taken;
   int   send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready)
            predict_updates(item_type'(req_bus.req_type), req_bus.byte_value);
      end
   end

   always @(negedge clock) begin
      link_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= $urandom_range(0, 11);
         end else if (link_items.size() > 0) begin
            it = link_items.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.req_type   <= it.kind;
            req_bus.byte_value <= it.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response side: random stall bursts, in-order field compare
   // ------------------------------------------------------------------

   int stall_left;

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 11);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      channel_update_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_updates.size() == 0) begin
            $error("unexpected update: channel %0d pulse_us %0d cause %0d last %0d",
                   rsp_bus.channel, rsp_bus.pulse_us, rsp_bus.cause, rsp_bus.last);
            mismatches++;
         end else begin
            want = expected_updates.pop_front();
            if (rsp_bus.channel !== want.channel) begin
               $error("channel: expected %0d, got %0d", want.channel, rsp_bus.channel);
               mismatches++;
            end
            if (rsp_bus.pulse_us !== want.pulse_us) begin
               $error("pulse_us: expected %0d, got %0d", want.pulse_us, rsp_bus.pulse_us);
               mismatches++;
            end
            if (rsp_bus.cause !== want.cause) begin
               $error("cause: expected %0d, got %0d", want.cause, rsp_bus.cause);
               mismatches++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any transfer or register write counts as progress.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      logic [15:0]        edge_cmds [CHANNELS];
      logic [PULSE_W-1:0] floor_us;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = ITEM_BYTE;
      req_bus.byte_value = '0;
      rsp_bus.ready      = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_START_BYTE;
      csr_wdata          = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset defaults: stray bytes before any start byte, then one
      // frame covering zero, full scale, over-range and in-range commands.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      edge_cmds = '{16'd0, 16'd2000, 16'd2001, 16'hFFFF, 16'd1, 16'd1999, 16'h8000, 16'h00FF};
      queue_frame(edge_cmds, 1'b0, 1'b0);
      wait_for_quiet();

      // Timeout of one tick: an open frame is dropped by the tripping tick, and
      // the tick after it stays silent while failsafe holds.
      load_config(rx_cfg.start_byte, 24'd1, rx_cfg.pulse_min, rx_cfg.pulse_max,
                  rx_cfg.pulse_neutral);
      queue_byte(rx_cfg.start_byte);
      queue_byte(8'h34);
      queue_byte(8'h12);
      repeat (3) queue_tick();
      wait_for_quiet();

      // Top start byte, timeout that never fires, full pulse range.
      load_config(8'hFF, 24'hFFFFFF, 12'd0, 12'd4095, 12'd4095);
      queue_random_traffic(PHASE_ITEMS);
      wait_for_quiet();

      // Zero start byte, timeout of one tick, inverted range (zero span).
      load_config(8'h00, 24'd1, 12'd4095, 12'd0, 12'd0);
      queue_random_traffic(PHASE_ITEMS);
      wait_for_quiet();

      // Fully random registers; the sender drains completely halfway through.
      load_config(BYTE_W'($urandom), TICK_W'($urandom_range(2, 40)), PULSE_W'($urandom),
                  PULSE_W'($urandom), PULSE_W'($urandom));
      queue_random_traffic(PHASE_ITEMS / 2);
      wait_for_quiet();
      queue_random_traffic(PHASE_ITEMS / 2);
      wait_for_quiet();

      // Ordinary ordered range.
      floor_us = PULSE_W'($urandom_range(0, 2000));
      load_config(BYTE_W'($urandom), TICK_W'($urandom_range(2, 40)), floor_us,
                  PULSE_W'($urandom_range(floor_us, 4095)), PULSE_W'($urandom));
      queue_random_traffic(PHASE_ITEMS);
      wait_for_quiet();

      // Closing stretch at full rate on both sides.
      idling_on = 1'b0;
      load_config(BYTE_W'($urandom), TICK_W'($urandom_range(2, 40)), PULSE_W'($urandom),
                  PULSE_W'($urandom), PULSE_W'($urandom));
      queue_random_traffic(PHASE_ITEMS);
      wait_for_quiet();

      if (mismatches == 0 && expected_updates.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
